[design/cbt_pkg.sv]
// Package for the cubic Bezier tessellator: fixed widths, register codes,
// reset values and the per-point sideband struct. No dependencies.
`timescale 1ns / 1ps

package cbt_pkg;

  localparam int TW = 17;   // Q1.16 parameter, 1.0 included
  localparam int KW = 6;    // point index width
  localparam int CFG_DW = 17;

  localparam logic [TW-1:0] TOne = TW'(65536);

  // register indexes
  localparam logic CfgPointCount = 1'b0;
  localparam logic CfgTStep      = 1'b1;

  localparam logic [KW-1:0] PointCountRst = KW'(10);
  localparam logic [TW-1:0] TStepRst      = TW'(6554);

  typedef struct packed {
    logic [TW-1:0] t;
    logic [KW-1:0] k;
    logic          last;
  } side_t;

endpackage

[design/cbt_lerp.sv]
// Two-stage pipelined fixed-point lerp: a + ((b - a) * t) >>> 16.
// Uses cbt_pkg for the parameter width.
`timescale 1ns / 1ps

module cbt_lerp #(
  parameter int W = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [W-1:0]      a_i,
  input  logic signed [W-1:0]      b_i,
  input  logic [cbt_pkg::TW-1:0]   t_i,
  output logic signed [W-1:0]      res_o
);
  import cbt_pkg::*;

  localparam int PW = W + TW + 2;

  logic signed [W:0]    diff;
  logic signed [TW:0]   t_s;
  logic signed [PW-1:0] prod_d, prod_q, shifted;
  logic signed [W-1:0]  a_q, res_d, res_q;

  always_comb begin
    diff    = (W+1)'(b_i) - (W+1)'(a_i);
    t_s     = signed'({1'b0, t_i});
    prod_d  = PW'(diff) * PW'(t_s);
    shifted = prod_q >>> 16;
    // result stays between a and b, so truncation is exact
    res_d   = a_q + shifted[W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      a_q    <= a_i;
      res_q  <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

[design/cubic_bezier_segment_tessellator.sv]
// Cubic Bezier segment tessellator, de Casteljau in fixed point.
// Depends on cbt_pkg and cbt_lerp.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one segment item: start,
//   two control and end points, signed Q2.14. The output channel
//   (out_valid_o / out_stall_i) gives point_count+1 points per segment
//   (capped at MAX_POINTS), at t = 0, t_step, 2*t_step ... saturated at 1.0,
//   with point_index and a last flag on the final point.
//   Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i
//   (0 = point_count, 1 = t_step); write only while idle.
// Timing:
//   The point sequencer issues one point per cycle, unless stalled, into a
//   six-stage lerp pipeline (three levels of multiply then add) and an output
//   register. An accepted item first loads the sequencer registers, and its
//   points then pass through the lerp stages and the output register; the next
//   item is taken in the cycle its predecessor's last point issues.
// Reset: clears all valid bits and the sequencer, registers go to
//   point_count = 10, t_step = 6554.
// Stall: with out_valid_o high, out_stall_i freezes the whole pipeline and the
//   sequencer; nothing is lost or repeated, the held point stays on the outputs.
`timescale 1ns / 1ps

module cubic_bezier_segment_tessellator #(
  parameter int COORD_WIDTH = 16,
  parameter int MAX_POINTS  = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [cbt_pkg::CFG_DW-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]   start_x_i,
  input  logic signed [COORD_WIDTH-1:0]   start_y_i,
  input  logic signed [COORD_WIDTH-1:0]   ctrl1_x_i,
  input  logic signed [COORD_WIDTH-1:0]   ctrl1_y_i,
  input  logic signed [COORD_WIDTH-1:0]   ctrl2_x_i,
  input  logic signed [COORD_WIDTH-1:0]   ctrl2_y_i,
  input  logic signed [COORD_WIDTH-1:0]   end_x_i,
  input  logic signed [COORD_WIDTH-1:0]   end_y_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [COORD_WIDTH-1:0]   point_x_o,
  output logic signed [COORD_WIDTH-1:0]   point_y_o,
  output logic [cbt_pkg::KW-1:0]          point_index_o,
  output logic                            last_o
);
  import cbt_pkg::*;

  localparam int W = COORD_WIDTH;
  localparam int NS = 6;
  localparam logic [KW-1:0] LastMax = KW'(MAX_POINTS - 1);

  // configuration
  logic [KW-1:0] point_count_q;
  logic [TW-1:0] t_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= PointCountRst;
      t_step_q      <= TStepRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPointCount: point_count_q <= cfg_data_i[KW-1:0];
        CfgTStep:      t_step_q      <= cfg_data_i[TW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  logic                busy_q, adv, in_acc, k_last;
  logic [KW-1:0]       k_q, last_k;
  logic [TW-1:0]       t_q, t_d;
  logic [TW:0]         t_sum;
  logic signed [W-1:0] px_q [4];
  logic signed [W-1:0] py_q [4];

  assign adv = !out_valid_o || !out_stall_i;

  always_comb begin
    last_k     = (point_count_q > LastMax) ? LastMax : point_count_q;
    k_last     = (k_q == last_k);
    in_stall_o = busy_q && !(adv && k_last);
    in_acc     = in_valid_i && !in_stall_o;
    t_sum      = {1'b0, t_q} + {1'b0, t_step_q};
    t_d        = (t_sum > {1'b0, TOne}) ? TOne : t_sum[TW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
      t_q    <= '0;
    end else if (in_acc) begin
      busy_q <= 1'b1;
      k_q    <= '0;
      t_q    <= '0;
    end else if (busy_q && adv) begin
      busy_q <= !k_last;
      k_q    <= k_q + KW'(1);
      t_q    <= t_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q[0] <= start_x_i; py_q[0] <= start_y_i;
      px_q[1] <= ctrl1_x_i; py_q[1] <= ctrl1_y_i;
      px_q[2] <= ctrl2_x_i; py_q[2] <= ctrl2_y_i;
      px_q[3] <= end_x_i;   py_q[3] <= end_y_i;
    end
  end

  // valid and sideband pipeline
  logic  v_q    [NS];
  side_t side_q [NS];
  side_t side_d;

  always_comb begin
    side_d.t    = t_q;
    side_d.k    = k_q;
    side_d.last = k_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NS; s++) v_q[s] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= busy_q;
      for (int s = 1; s < NS; s++) v_q[s] <= v_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_d;
      for (int s = 1; s < NS; s++) side_q[s] <= side_q[s-1];
    end
  end

  // lerp levels
  logic signed [W-1:0] l1x [3];
  logic signed [W-1:0] l1y [3];
  logic signed [W-1:0] l2x [2];
  logic signed [W-1:0] l2y [2];
  logic signed [W-1:0] l3x, l3y;

  for (genvar i = 0; i < 3; i++) begin : g_lvl1
    cbt_lerp #(.W(W)) u_x (.clk_i, .en_i(adv), .a_i(px_q[i]), .b_i(px_q[i+1]),
                           .t_i(t_q), .res_o(l1x[i]));
    cbt_lerp #(.W(W)) u_y (.clk_i, .en_i(adv), .a_i(py_q[i]), .b_i(py_q[i+1]),
                           .t_i(t_q), .res_o(l1y[i]));
  end

  for (genvar i = 0; i < 2; i++) begin : g_lvl2
    cbt_lerp #(.W(W)) u_x (.clk_i, .en_i(adv), .a_i(l1x[i]), .b_i(l1x[i+1]),
                           .t_i(side_q[1].t), .res_o(l2x[i]));
    cbt_lerp #(.W(W)) u_y (.clk_i, .en_i(adv), .a_i(l1y[i]), .b_i(l1y[i+1]),
                           .t_i(side_q[1].t), .res_o(l2y[i]));
  end

  cbt_lerp #(.W(W)) u_lvl3_x (.clk_i, .en_i(adv), .a_i(l2x[0]), .b_i(l2x[1]),
                              .t_i(side_q[3].t), .res_o(l3x));
  cbt_lerp #(.W(W)) u_lvl3_y (.clk_i, .en_i(adv), .a_i(l2y[0]), .b_i(l2y[1]),
                              .t_i(side_q[3].t), .res_o(l3y));

  // output register
  logic                out_valid_q;
  logic signed [W-1:0] point_x_q, point_y_q;
  logic [KW-1:0]       point_index_q;
  logic                last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      point_x_q     <= l3x;
      point_y_q     <= l3y;
      point_index_q <= side_q[NS-1].k;
      last_q        <= side_q[NS-1].last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign point_x_o     = point_x_q;
  assign point_y_o     = point_y_q;
  assign point_index_o = point_index_q;
  assign last_o        = last_q;

  // checks
  a_acc_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> busy_q && (k_q == '0) && (t_q == '0))
    else $error("sequencer did not restart on accepted item");

  a_t_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    t_q <= TOne)
    else $error("t exceeds 1.0");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(point_index_o)
                                   && $stable(last_o))
    else $error("stalled point changed");

  a_first_t0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && (side_q[0].k == '0) |-> (side_q[0].t == '0))
    else $error("first point of segment not at t = 0");

endmodule
